@@ src/srts_pkg.sv @@
// Package: shared widths, command codes and controller/datapath interface types.
package srts_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int POS_WIDTH_DEF   = 32;

    localparam int CMD_W   = 2;
    localparam int ENTRY_W = 8;
    localparam int FIELD_W = 32;
    localparam int COUNT_W = 9;
    localparam int RES_W   = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE      = 2'd0,
        CMD_HOLE       = 2'd1,
        CMD_CONTAINS   = 2'd2,
        CMD_INTERSECTS = 2'd3
    } cmd_code_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } srts_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run;
        logic done;
    } srts_stat_t;

endpackage

@@ src/srts_ctrl.sv @@
// Controller: sequences acceptance, search probes and the result register.
module srts_ctrl
    import srts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  srts_stat_t stat,
    output srts_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctrl         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = stat.run ? ST_PROBE : ST_DONE;
                end
            end
            ST_PROBE: begin
                ctrl.step = 1'b1;
                if (stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // The result register must be empty or emptying this cycle.
                if (!m_valid_reg || m_ready) begin
                    ctrl.emit    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ src/srts_datapath.sv @@
// Datapath: range table memory, search bounds, probe comparison and result registers.
module srts_datapath
    import srts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [ENTRY_W-1:0] s_entry_index,
    input  logic [FIELD_W-1:0] s_range_start,
    input  logic [FIELD_W-1:0] s_range_length,
    input  logic [COUNT_W-1:0] s_active_count,
    input  srts_ctrl_t         ctrl,
    output srts_stat_t         stat,
    output logic               m_found,
    output logic [RES_W-1:0]   m_result_index
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int END_W = POS_WIDTH + 1;
    localparam int ENT_W = 2 * POS_WIDTH;

    logic [ENT_W-1:0]     mem [TABLE_DEPTH];
    logic [ENT_W-1:0]     rd_a_reg;
    logic [POS_WIDTH-1:0] rd_b_reg;
    logic [IDX_W-1:0]     rd_addr, rd_addr_b;

    cmd_code_t            op_reg;
    logic [POS_WIDTH-1:0] qs_reg;
    logic [END_W-1:0]     qe_reg;
    logic [CNT_W-1:0]     first_reg, hi_reg;
    logic [IDX_W-1:0]     mid_reg;
    logic                 res_found_reg;
    logic [RES_W-1:0]     res_index_reg;
    logic                 out_found_reg;
    logic [RES_W-1:0]     out_index_reg;

    // Input side
    cmd_code_t            in_op;
    logic [CNT_W-1:0]     n_cnt;
    logic [IDX_W-1:0]     init_mid;
    logic [POS_WIDTH-1:0] qs_in, len_in;
    logic [END_W-1:0]     qe_in;
    logic                 wr_en;

    // Probe side
    logic [POS_WIDTH-1:0] es, el, es_nx;
    logic [END_W-1:0]     ee;
    logic [CNT_W-1:0]     mid_w, mid_p1, first_nx, hi_nx;
    logic [SUM_W-1:0]     sum_r, sum_l;
    logic [IDX_W-1:0]     mid_nx;
    logic                 is_last, go_right, hit, cont;

    always_comb begin
        in_op  = cmd_code_t'(s_cmd);
        qs_in  = s_range_start[POS_WIDTH-1:0];
        len_in = s_range_length[POS_WIDTH-1:0];
        qe_in  = {1'b0, qs_in} + {1'b0, len_in};
        if (32'(s_active_count) > 32'(TABLE_DEPTH)) begin
            n_cnt = CNT_W'(TABLE_DEPTH);
        end else begin
            n_cnt = CNT_W'(s_active_count);
        end
        init_mid = IDX_W'((n_cnt - CNT_W'(1)) >> 1);
        wr_en    = ctrl.load && (in_op == CMD_WRITE)
                   && (32'(s_entry_index) < 32'(TABLE_DEPTH));
    end

    always_comb begin
        es     = rd_a_reg[POS_WIDTH-1:0];
        el     = rd_a_reg[ENT_W-1:POS_WIDTH];
        es_nx  = rd_b_reg;
        ee     = {1'b0, es} + {1'b0, el};
        mid_w  = CNT_W'(mid_reg);
        mid_p1 = mid_w + CNT_W'(1);
        is_last = (mid_p1 == hi_reg);
        case (op_reg)
            CMD_HOLE: begin
                go_right = es < qs_reg;
                hit      = go_right && (is_last || (es_nx > qs_reg));
            end
            CMD_CONTAINS: begin
                go_right = es <= qs_reg;
                hit      = go_right && (qe_reg <= ee);
            end
            CMD_INTERSECTS: begin
                go_right = {1'b0, es} < qe_reg;
                hit      = go_right && (el != '0) && ({1'b0, qs_reg} < ee);
            end
            default: begin
                go_right = 1'b0;
                hit      = 1'b0;
            end
        endcase
        // Both candidate midpoints are formed in parallel with the compare.
        first_nx = go_right ? mid_p1 : first_reg;
        hi_nx    = go_right ? hi_reg : mid_w;
        cont     = go_right ? (mid_p1 < hi_reg) : (first_reg < mid_w);
        sum_r    = SUM_W'(mid_w) + SUM_W'(hi_reg);
        sum_l    = SUM_W'(first_reg) + SUM_W'(mid_w) - SUM_W'(1);
        mid_nx   = go_right ? IDX_W'(sum_r >> 1) : IDX_W'(sum_l >> 1);
        stat.done = hit || !cont;
        // Zero-length match queries and empty tables finish without probing.
        stat.run = (in_op != CMD_WRITE) && (n_cnt != '0)
                   && ((in_op == CMD_HOLE) || (len_in != '0));
    end

    assign rd_addr   = ctrl.load ? init_mid : mid_nx;
    assign rd_addr_b = rd_addr + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[IDX_W'(s_entry_index)] <= {len_in, qs_in};
        end
        rd_a_reg <= mem[rd_addr];
        rd_b_reg <= mem[rd_addr_b][POS_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            op_reg        <= in_op;
            qs_reg        <= qs_in;
            qe_reg        <= qe_in;
            first_reg     <= '0;
            hi_reg        <= n_cnt;
            mid_reg       <= init_mid;
            res_found_reg <= 1'b0;
            res_index_reg <= '0;
        end else if (ctrl.step) begin
            first_reg <= first_nx;
            hi_reg    <= hi_nx;
            mid_reg   <= mid_nx;
            if (hit) begin
                res_found_reg <= (op_reg != CMD_HOLE);
                res_index_reg <= (op_reg == CMD_HOLE) ? RES_W'(mid_p1) : RES_W'(mid_w);
            end else if (!cont) begin
                res_found_reg <= 1'b0;
                res_index_reg <= (op_reg == CMD_HOLE) ? RES_W'(hi_nx) : '0;
            end
        end
        if (ctrl.emit) begin
            out_found_reg <= res_found_reg;
            out_index_reg <= res_index_reg;
        end
    end

    assign m_found        = out_found_reg;
    assign m_result_index = out_index_reg;

endmodule

@@ src/sorted_range_table_search.sv @@
// Top level: sorted range table with binary search queries.
//
//   channel   direction  ports
//   s_*       in         s_valid, s_ready, s_cmd, s_entry_index, s_range_start,
//                        s_range_length, s_active_count
//   m_*       out        m_valid, m_ready, m_found, m_result_index
//
// One transaction is worked on at a time. A write goes from acceptance to the
// done state and then to the output register; a query first makes its probes, at
// most ceil(log2(active_count + 1)) (9 for 256 entries), one probe per cycle of the
// dual-read table memory. The next transaction can be accepted in the same cycle
// as the result is presented. Reset clears only control state; the table is
// undefined until written. A stalled result waits in the output register and
// holds the search result behind it until the register frees.
module sorted_range_table_search
    import srts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [ENTRY_W-1:0] s_entry_index,
    input  logic [FIELD_W-1:0] s_range_start,
    input  logic [FIELD_W-1:0] s_range_length,
    input  logic [COUNT_W-1:0] s_active_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [RES_W-1:0]   m_result_index
);

    srts_ctrl_t ctrl;
    srts_stat_t stat;

    srts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    srts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POS_WIDTH   (POS_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .s_cmd          (s_cmd),
        .s_entry_index  (s_entry_index),
        .s_range_start  (s_range_start),
        .s_range_length (s_range_length),
        .s_active_count (s_active_count),
        .ctrl           (ctrl),
        .stat           (stat),
        .m_found        (m_found),
        .m_result_index (m_result_index)
    );

endmodule

@@ verif/range_search_checker.sv @@
// Checker: watches both channels, predicts each lookup result and compares it with the block.
module range_search_checker
    import srts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [ENTRY_W-1:0] s_entry_index,
    input  logic [FIELD_W-1:0] s_range_start,
    input  logic [FIELD_W-1:0] s_range_length,
    input  logic [COUNT_W-1:0] s_active_count,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_found,
    input  logic [RES_W-1:0]   m_result_index,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        cmd_code_t        cmd;
        logic             found;
        logic [RES_W-1:0] index;
    } lookup_result_t;

    lookup_result_t     expected_q [$];
    logic [FIELD_W-1:0] entry_start [TABLE_DEPTH_DEF] = '{default: '0};
    logic [FIELD_W-1:0] entry_len [TABLE_DEPTH_DEF] = '{default: '0};
    int                 mismatches = 0;
    int                 outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("%0t: range_search_checker: %s expected %0d got %0d", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // Insertion point for pos, following the block's probe order even on unsorted tables.
    function automatic logic [RES_W-1:0] hole_position(input int n, input logic [FIELD_W-1:0] pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (entry_start[mid] < pos) begin
                if (mid == hi || entry_start[mid + 1] > pos)
                    return RES_W'(mid + 1);
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return RES_W'(hi + 1);
    endfunction

    // Index of the entry that holds (or overlaps) the query range, or -1.
    function automatic int find_match(input int n, input logic [FIELD_W-1:0] qs,
                                      input logic [FIELD_W-1:0] ql, input logic holds);
        logic [FIELD_W:0] q_lo;
        logic [FIELD_W:0] q_hi;
        logic [FIELD_W:0] e_lo;
        logic [FIELD_W:0] e_hi;
        logic [FIELD_W:0] ov_lo;
        logic [FIELD_W:0] ov_hi;
        logic             go_right;
        int               lo;
        int               hi;
        int               mid;
        // Ends are one bit wider than positions, so they never wrap.
        q_lo = {1'b0, qs};
        q_hi = q_lo + {1'b0, ql};
        if (ql == '0)
            return -1;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid  = (lo + hi) / 2;
            e_lo = {1'b0, entry_start[mid]};
            e_hi = e_lo + {1'b0, entry_len[mid]};
            if (holds) begin
                go_right = (e_lo <= q_lo);
                if (go_right && q_hi <= e_hi)
                    return mid;
            end else begin
                go_right = (e_lo < q_hi);
                ov_lo    = (e_lo > q_lo) ? e_lo : q_lo;
                ov_hi    = (e_hi < q_hi) ? e_hi : q_hi;
                if (go_right && entry_len[mid] != '0 && ov_hi > ov_lo)
                    return mid;
            end
            if (go_right)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic lookup_result_t predict_lookup(input cmd_code_t cmd,
                                                      input logic [ENTRY_W-1:0] slot,
                                                      input logic [FIELD_W-1:0] start,
                                                      input logic [FIELD_W-1:0] len,
                                                      input logic [COUNT_W-1:0] count);
        lookup_result_t r;
        int             n;
        int             hit;
        r     = '0;
        r.cmd = cmd;
        n     = (count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(count);
        case (cmd)
            CMD_WRITE: begin
                entry_start[slot] = start;
                entry_len[slot]   = len;
            end
            CMD_HOLE: begin
                r.index = hole_position(n, start);
            end
            default: begin
                hit = find_match(n, start, len, cmd == CMD_CONTAINS);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.index = RES_W'(hit);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        lookup_result_t exp_r;
        cmd_code_t      exp_cmd;
        if (aresetn) begin
            // A result can never belong to the transaction accepted on the same edge.
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, result_index", -1, int'(m_result_index));
                end else begin
                    exp_r   = expected_q.pop_front();
                    exp_cmd = exp_r.cmd;
                    if (m_found !== exp_r.found)
                        report_mismatch({exp_cmd.name(), " found"}, int'(exp_r.found),
                                        int'(m_found));
                    if (m_result_index !== exp_r.index)
                        report_mismatch({exp_cmd.name(), " result_index"}, int'(exp_r.index),
                                        int'(m_result_index));
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_lookup(cmd_code_t'(s_cmd), s_entry_index,
                                                    s_range_start, s_range_length,
                                                    s_active_count));
            outstanding <= expected_q.size();
        end
    end

endmodule

@@ verif/sorted_range_table_search_tb.sv @@
// Testbench top: clock, reset, stimulus and verdict for the sorted range table search block.
module sorted_range_table_search_tb;
    import srts_pkg::*;

    localparam int ITEM_TARGET    = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_FOURTH,
        READY_SPARSE
    } ready_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd = '0;
    logic [ENTRY_W-1:0] s_entry_index = '0;
    logic [FIELD_W-1:0] s_range_start = '0;
    logic [FIELD_W-1:0] s_range_length = '0;
    logic [COUNT_W-1:0] s_active_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic [RES_W-1:0]   m_result_index;

    int                 fail_count;
    int                 pending;
    int                 sent = 0;
    int                 burst_left = 0;
    int                 idle_cycles = 0;
    int                 ready_cycle = 0;
    ready_mode_t        ready_mode = READY_ALWAYS;

    // Stimulus copy of the table contents, used only to aim queries at entries.
    logic [FIELD_W-1:0] gen_start [TABLE_DEPTH_DEF] = '{default: '0};
    logic [FIELD_W-1:0] gen_len [TABLE_DEPTH_DEF] = '{default: '0};

    always #2 aclk = ~aclk;

    sorted_range_table_search u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_entry_index  (s_entry_index),
        .s_range_start  (s_range_start),
        .s_range_length (s_range_length),
        .s_active_count (s_active_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_result_index (m_result_index)
    );

    range_search_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_entry_index  (s_entry_index),
        .s_range_start  (s_range_start),
        .s_range_length (s_range_length),
        .s_active_count (s_active_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_result_index (m_result_index),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // The receiver periodically picks a new stall pattern at random.
    always @(posedge aclk) begin
        if (ready_cycle % 50 == 0)
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
        ready_cycle <= ready_cycle + 1;
        case (ready_mode)
            READY_ALWAYS:       m_ready <= 1'b1;
            READY_COIN:         m_ready <= 1'($urandom_range(0, 1));
            READY_EVERY_FOURTH: m_ready <= (ready_cycle % 4 == 0);
            default:            m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_range_table_search_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_txn(input cmd_code_t cmd, input logic [ENTRY_W-1:0] slot,
                            input logic [FIELD_W-1:0] start, input logic [FIELD_W-1:0] len,
                            input logic [COUNT_W-1:0] count);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_entry_index  <= slot;
        s_range_start  <= start;
        s_range_length <= len;
        s_active_count <= count;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent++;
    endtask

    task automatic write_entry(input logic [ENTRY_W-1:0] slot, input logic [FIELD_W-1:0] start,
                               input logic [FIELD_W-1:0] len);
        gen_start[slot] = start;
        gen_len[slot]   = len;
        send_txn(CMD_WRITE, slot, start, len, COUNT_W'($urandom_range(0, 511)));
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Writes slots 0..k-1 with ascending starts; a large shift gives repeated starts.
    task automatic load_sorted_table(input int k);
        logic [FIELD_W:0] pos;
        logic [FIELD_W-1:0] len;
        int shift;
        int i;
        shift = (k > 64) ? $urandom_range(8, 24) : $urandom_range(4, 31);
        pos   = ($urandom_range(0, 3) == 0) ? '0
                                             : {1'b0, $urandom() >> $urandom_range(0, 31)};
        for (i = 0; i < k; i++) begin
            case ($urandom_range(0, 7))
                0:       len = '0;
                1:       len = $urandom();
                default: len = $urandom() >> $urandom_range(shift, 31);
            endcase
            write_entry(ENTRY_W'(i), (pos > {1'b0, {FIELD_W{1'b1}}}) ? '1 : pos[FIELD_W-1:0], len);
            pos = pos + ($urandom() >> shift);
        end
    endtask

    // Mostly queries aimed at the edges of entries, with stray writes that break the order.
    task automatic run_queries(input int k, input int n_q);
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [COUNT_W-1:0] count;
        int e;
        int i;
        int pick;
        for (i = 0; i < n_q; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                write_entry(ENTRY_W'($urandom()), $urandom(), $urandom());
            end else begin
                e = $urandom_range(0, k - 1);
                case ($urandom_range(0, 4))
                    0:       start = $urandom();
                    1:       start = gen_start[e];
                    2:       start = gen_start[e] + $urandom_range(0, gen_len[e]);
                    3:       start = gen_start[e] + gen_len[e] - $urandom_range(0, 2);
                    default: start = gen_start[e] - $urandom_range(1, 3);
                endcase
                case ($urandom_range(0, 5))
                    0:       len = $urandom();
                    1:       len = '0;
                    2:       len = gen_len[e];
                    default: len = $urandom_range(1, 16);
                endcase
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    count = COUNT_W'(k);
                else if (pick < 9)
                    count = COUNT_W'($urandom_range(0, k));
                else
                    count = COUNT_W'($urandom_range(0, 511));
                send_txn(cmd_code_t'($urandom_range(1, 3)), ENTRY_W'($urandom()), start, len,
                         count);
            end
        end
    endtask

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table: no entry is probed.
        send_txn(CMD_HOLE, 8'd0, 32'h0000_0055, 32'd1, 9'd0);
        send_txn(CMD_CONTAINS, 8'd0, 32'h0000_0055, 32'd1, 9'd0);
        send_txn(CMD_INTERSECTS, 8'd0, 32'h0000_0055, 32'd1, 9'd0);

        // Small table with zero-length entries and an end beyond the position range.
        write_entry(8'd0, 32'h0000_0000, 32'h0000_0000);
        write_entry(8'd1, 32'h0000_0010, 32'h0000_0010);
        write_entry(8'd2, 32'h0000_0020, 32'h0000_0000);
        write_entry(8'd3, 32'h0000_0100, 32'h0000_0100);
        write_entry(8'd4, 32'h8000_0000, 32'h7FFF_FFFF);
        write_entry(8'd5, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        write_entry(8'd255, 32'hA5A5_5A5A, 32'h5A5A_A5A5);

        send_txn(CMD_HOLE, 8'd0, 32'h0000_0000, 32'd1, 9'd6);
        send_txn(CMD_HOLE, 8'd0, 32'h0000_0018, 32'd1, 9'd6);
        send_txn(CMD_HOLE, 8'd0, 32'h0000_0020, 32'd1, 9'd6);
        send_txn(CMD_HOLE, 8'd0, 32'hFFFF_FFFF, 32'd1, 9'd6);
        send_txn(CMD_CONTAINS, 8'd0, 32'h0000_0012, 32'd4, 9'd6);
        send_txn(CMD_CONTAINS, 8'd0, 32'h0000_0020, 32'd0, 9'd6);
        send_txn(CMD_CONTAINS, 8'd0, 32'h0000_0020, 32'd1, 9'd6);
        send_txn(CMD_CONTAINS, 8'd0, 32'hFFFF_FFF8, 32'h0000_0100, 9'd6);
        send_txn(CMD_CONTAINS, 8'd0, 32'hFFFF_FFF8, 32'hFFFF_FFFF, 9'd6);
        send_txn(CMD_INTERSECTS, 8'd0, 32'h0000_001F, 32'd2, 9'd6);
        send_txn(CMD_INTERSECTS, 8'd0, 32'h0000_0020, 32'd1, 9'd6);
        send_txn(CMD_INTERSECTS, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 9'd6);
        send_txn(CMD_INTERSECTS, 8'd0, 32'h0000_0014, 32'd0, 9'd6);
        send_txn(CMD_INTERSECTS, 8'd0, 32'h0000_0000, 32'd1, 9'd1);

        // Once every slot holds a value, any active count may be used.
        load_sorted_table(TABLE_DEPTH_DEF);
        send_txn(CMD_HOLE, 8'd0, gen_start[200], 32'd1, 9'd511);
        send_txn(CMD_CONTAINS, 8'd0, gen_start[17], 32'd1, 9'd257);
        send_txn(CMD_INTERSECTS, 8'd0, gen_start[255], 32'd1, 9'd256);
        run_queries(TABLE_DEPTH_DEF, 30);
        wait_all_results();

        while (sent < ITEM_TARGET) begin
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 128) : $urandom_range(1, 24);
            load_sorted_table(k);
            run_queries(k, $urandom_range(4, 24));
            if ($urandom_range(0, 3) == 0)
                wait_all_results();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("sorted_range_table_search_tb: PASS");
        else
            $display("sorted_range_table_search_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/srts_pkg.sv
src/srts_ctrl.sv
src/srts_datapath.sv
src/sorted_range_table_search.sv
verif/range_search_checker.sv
verif/sorted_range_table_search_tb.sv
